### design/hds_pkg.sv
// Shared types and constants for the heat diffusion stencil block.
package hds_pkg;

    localparam int TEMP_W     = 24;
    localparam int COEF_W     = 16;
    localparam int DIFF_W     = TEMP_W + 1;
    localparam int PROD_W     = DIFF_W + COEF_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int FRAC_DROP  = 16;
    localparam int NV_W       = SUM_W - FRAC_DROP + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int AW_W       = 6;
    localparam int AH_W       = 13;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [COEF_W-1:0]        coef_t;

    localparam temp_t TEMP_MAX = 24'sh7FFFFF;
    localparam temp_t TEMP_MIN = 24'sh800000;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << (FRAC_DROP - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_X        = 3'd0,
        REG_COEF_Y        = 3'd1,
        REG_EDGE_TEMP     = 3'd2,
        REG_ACTIVE_WIDTH  = 3'd3,
        REG_ACTIVE_HEIGHT = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        temp_t temperature;
        logic  fixed_cell;
        logic  insulated_left;
        logic  insulated_right;
        logic  insulated_down;
        logic  insulated_up;
    } cell_beat_t;

    typedef struct packed {
        temp_t new_temperature;
        logic  saturated;
        logic  last_of_grid;
    } result_beat_t;

    typedef struct packed {
        cell_beat_t center;
        temp_t      left;
        temp_t      right;
        temp_t      down;
    } view_t;

    typedef struct packed {
        cell_beat_t center;
        temp_t      left;
        temp_t      right;
        temp_t      down;
        temp_t      up;
        logic       last;
    } stencil_t;

endpackage

### design/heat_diffusion_stencil_step.sv
// Top level of the heat diffusion stencil: configuration, raster counters and the column cells.
//
//  Channel  Handshake                Payload                      Side
//  cell     cell_valid / cell_stall  cell_data   (cell_beat_t)    in
//  result   result_valid / result_stall result_data (result_beat_t) out
//  cfg      cfg_valid / cfg_ready    cfg_index, cfg_data          in
//
// One cell beat is taken per cycle unless cell_stall is high; from the second row on, each
// beat yields the result for the cell one row below through the s1, product, sum and output
// registers. The final beat of a grid raises cell_stall while the top row is drained,
// one result per cycle from the column cells while result_stall does not hold the pipeline.
// Reset clears the counters and the pipeline valids, zeroes the coefficients and the edge
// temperature and sets width and height to 32; the line store is not cleared. Apart from the
// drain, cell_stall rises only when every pipeline stage is full behind result_stall.
module heat_diffusion_stencil_step #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cell_valid,
    output logic                                cell_stall,
    input  hds_pkg::cell_beat_t                 cell_data,
    output logic                                result_valid,
    input  logic                                result_stall,
    output hds_pkg::result_beat_t               result_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hds_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    hds_pkg::coef_t              coef_x_reg;
    hds_pkg::coef_t              coef_y_reg;
    hds_pkg::temp_t              edge_reg;
    logic [hds_pkg::AW_W-1:0]    width_reg;
    logic [hds_pkg::AH_W-1:0]    height_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          flush_reg, flush_next;
    logic [CW-1:0] fcol_reg, fcol_next;

    logic [CW-1:0] wm1;
    logic [RW-1:0] hm1;
    logic          last_col, last_row;
    logic          cell_accept, stream_issue, flush_issue, issue_valid, issue_ready;
    logic [CW-1:0] idx;

    logic              cell_sel   [MAX_WIDTH];
    logic              cell_wr    [MAX_WIDTH];
    hds_pkg::temp_t    cur_value  [MAX_WIDTH];
    hds_pkg::temp_t    prev_value [MAX_WIDTH];
    hds_pkg::view_t    cell_view  [MAX_WIDTH];
    hds_pkg::view_t    view_any;
    hds_pkg::stencil_t stencil;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg <= '0;
            coef_y_reg <= '0;
            edge_reg   <= '0;
            width_reg  <= 6'd32;
            height_reg <= 13'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hds_pkg::REG_COEF_X:        coef_x_reg <= cfg_data[hds_pkg::COEF_W-1:0];
                hds_pkg::REG_COEF_Y:        coef_y_reg <= cfg_data[hds_pkg::COEF_W-1:0];
                hds_pkg::REG_EDGE_TEMP:     edge_reg   <= cfg_data[hds_pkg::TEMP_W-1:0];
                hds_pkg::REG_ACTIVE_WIDTH:  width_reg  <= cfg_data[hds_pkg::AW_W-1:0];
                hds_pkg::REG_ACTIVE_HEIGHT: height_reg <= cfg_data[hds_pkg::AH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            wm1 = '0;
        end
        else if (width_reg > hds_pkg::AW_W'(MAX_WIDTH))
        begin
            wm1 = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = CW'(width_reg - 6'd1);
        end

        if (height_reg < 13'd2)
        begin
            hm1 = RW'(1);
        end
        else if (height_reg > hds_pkg::AH_W'(MAX_HEIGHT))
        begin
            hm1 = RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            hm1 = RW'(height_reg - 13'd1);
        end
    end

    assign last_col = col_reg >= wm1;
    assign last_row = row_reg >= hm1;

    assign cell_stall   = flush_reg || ((row_reg != '0) && !issue_ready);
    assign cell_accept  = cell_valid && !cell_stall;
    assign stream_issue = cell_accept && (row_reg != '0);
    assign flush_issue  = flush_reg && issue_ready;
    assign issue_valid  = stream_issue || flush_issue;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        flush_next = flush_reg;
        fcol_next  = fcol_reg;
        if (cell_accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next   = '0;
                    flush_next = 1'b1;
                    fcol_next  = '0;
                end
                else
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
        if (flush_issue)
        begin
            if (fcol_reg >= wm1)
            begin
                flush_next = 1'b0;
            end
            else
            begin
                fcol_next = fcol_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            flush_reg <= 1'b0;
            fcol_reg  <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            flush_reg <= flush_next;
            fcol_reg  <= fcol_next;
        end
    end

    assign idx = flush_reg ? fcol_reg : col_reg;

    for (genvar k = 0; k < MAX_WIDTH; k++)
    begin : g_col
        hds_pkg::temp_t left_cur, left_prev, right_cur;

        assign cell_sel[k] = (idx == CW'(k));
        assign cell_wr[k]  = cell_sel[k] && cell_accept;

        if (k == 0)
        begin : g_first
            assign left_cur  = '0;
            assign left_prev = '0;
        end
        else
        begin : g_inner_left
            assign left_cur  = cur_value[k-1];
            assign left_prev = prev_value[k-1];
        end

        if (k == MAX_WIDTH - 1)
        begin : g_last
            assign right_cur = '0;
        end
        else
        begin : g_inner_right
            assign right_cur = cur_value[k+1];
        end

        hds_cell u_cell (
            .clk        (clk),
            .sel        (cell_sel[k]),
            .wr_en      (cell_wr[k]),
            .flush_mode (flush_reg),
            .wr_beat    (cell_data),
            .left_cur   (left_cur),
            .left_prev  (left_prev),
            .right_cur  (right_cur),
            .cur_value  (cur_value[k]),
            .prev_value (prev_value[k]),
            .view       (cell_view[k])
        );
    end

    always_comb
    begin
        view_any = '0;
        for (int k = 0; k < MAX_WIDTH; k++)
        begin
            view_any = view_any | cell_view[k];
        end
    end

    always_comb
    begin
        stencil.center = view_any.center;
        stencil.left   = (idx == '0) ? edge_reg : view_any.left;
        stencil.right  = (idx < wm1) ? view_any.right : edge_reg;
        stencil.down   = (!flush_reg && (row_reg == RW'(1))) ? edge_reg : view_any.down;
        stencil.up     = flush_reg ? edge_reg : cell_data.temperature;
        stencil.last   = flush_reg && (fcol_reg >= wm1);
    end

    hds_pipe u_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .issue_valid   (issue_valid),
        .issue_ready   (issue_ready),
        .issue_stencil (stencil),
        .coef_x        (coef_x_reg),
        .coef_y        (coef_y_reg),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_data   (result_data)
    );

endmodule

### design/hds_cell.sv
// One column of the line store: pending-row and previous-row entries and the local stencil view.
module hds_cell (
    input  logic                 clk,
    input  logic                 sel,
    input  logic                 wr_en,
    input  logic                 flush_mode,
    input  hds_pkg::cell_beat_t  wr_beat,
    input  hds_pkg::temp_t       left_cur,
    input  hds_pkg::temp_t       left_prev,
    input  hds_pkg::temp_t       right_cur,
    output hds_pkg::temp_t       cur_value,
    output hds_pkg::temp_t       prev_value,
    output hds_pkg::view_t       view
);

    hds_pkg::cell_beat_t cur_reg;
    hds_pkg::temp_t      prev_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prev_reg <= cur_reg.temperature;
            cur_reg  <= wr_beat;
        end
    end

    assign cur_value  = cur_reg.temperature;
    assign prev_value = prev_reg;

    always_comb
    begin
        view = '0;
        if (sel)
        begin
            view.center = cur_reg;
            view.left   = flush_mode ? left_cur : left_prev;
            view.right  = right_cur;
            view.down   = prev_reg;
        end
    end

endmodule

### design/hds_pipe.sv
// Arithmetic pipeline: weighted face differences, exact sum, rounding and saturation.
module hds_pipe (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  issue_valid,
    output logic                  issue_ready,
    input  hds_pkg::stencil_t     issue_stencil,
    input  hds_pkg::coef_t        coef_x,
    input  hds_pkg::coef_t        coef_y,
    output logic                  result_valid,
    input  logic                  result_stall,
    output hds_pkg::result_beat_t result_data
);

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic out_valid_reg, out_valid_next;

    logic out_ready, s3_ready, s2_ready, s1_ready;
    logic out_load, s3_load, s2_load, s1_load;

    hds_pkg::stencil_t s1_reg;

    logic signed [hds_pkg::PROD_W-1:0] prod_reg [4];
    logic signed [hds_pkg::PROD_W-1:0] prod_next [4];
    hds_pkg::temp_t                    s2_q_reg;
    logic                              s2_fixed_reg;
    logic                              s2_last_reg;

    logic signed [hds_pkg::SUM_W-1:0]  sum_reg, sum_next;
    hds_pkg::temp_t                    s3_q_reg;
    logic                              s3_fixed_reg;
    logic                              s3_last_reg;

    hds_pkg::result_beat_t out_reg, out_next;

    hds_pkg::temp_t                    nb [4];
    logic                              blocked [4];
    hds_pkg::coef_t                    wt [4];
    logic signed [hds_pkg::DIFF_W-1:0] diff [4];
    logic signed [hds_pkg::NV_W-1:0]   nv;

    assign out_ready = !out_valid_reg || !result_stall;
    assign out_load  = s3_valid_reg && out_ready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s3_load   = s2_valid_reg && s3_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s2_load   = s1_valid_reg && s2_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s1_load   = issue_valid && s1_ready;

    assign issue_ready = s1_ready;

    assign s1_valid_next  = s1_load  || (s1_valid_reg && !s2_ready);
    assign s2_valid_next  = s2_load  || (s2_valid_reg && !s3_ready);
    assign s3_valid_next  = s3_load  || (s3_valid_reg && !out_ready);
    assign out_valid_next = out_load || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        nb[0]      = s1_reg.left;
        nb[1]      = s1_reg.right;
        nb[2]      = s1_reg.down;
        nb[3]      = s1_reg.up;
        blocked[0] = s1_reg.center.insulated_left;
        blocked[1] = s1_reg.center.insulated_right;
        blocked[2] = s1_reg.center.insulated_down;
        blocked[3] = s1_reg.center.insulated_up;
        wt[0]      = coef_x;
        wt[1]      = coef_x;
        wt[2]      = coef_y;
        wt[3]      = coef_y;
        for (int i = 0; i < 4; i++)
        begin
            diff[i] = hds_pkg::DIFF_W'(nb[i]) - hds_pkg::DIFF_W'(s1_reg.center.temperature);
            if (blocked[i])
            begin
                prod_next[i] = '0;
            end
            else
            begin
                prod_next[i] = hds_pkg::PROD_W'($signed({1'b0, wt[i]}))
                             * hds_pkg::PROD_W'(diff[i]);
            end
        end
    end

    always_comb
    begin
        sum_next = hds_pkg::ROUND_HALF;
        for (int i = 0; i < 4; i++)
        begin
            sum_next = sum_next + hds_pkg::SUM_W'(prod_reg[i]);
        end
    end

    always_comb
    begin
        nv = hds_pkg::NV_W'(s3_q_reg)
           + hds_pkg::NV_W'($signed(sum_reg[hds_pkg::SUM_W-1:hds_pkg::FRAC_DROP]));
        out_next.last_of_grid = s3_last_reg;
        if (s3_fixed_reg)
        begin
            out_next.new_temperature = s3_q_reg;
            out_next.saturated       = 1'b0;
        end
        else if (nv > hds_pkg::NV_W'(hds_pkg::TEMP_MAX))
        begin
            out_next.new_temperature = hds_pkg::TEMP_MAX;
            out_next.saturated       = 1'b1;
        end
        else if (nv < hds_pkg::NV_W'(hds_pkg::TEMP_MIN))
        begin
            out_next.new_temperature = hds_pkg::TEMP_MIN;
            out_next.saturated       = 1'b1;
        end
        else
        begin
            out_next.new_temperature = hds_pkg::TEMP_W'(nv);
            out_next.saturated       = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= issue_stencil;
        end
        if (s2_load)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            s2_q_reg     <= s1_reg.center.temperature;
            s2_fixed_reg <= s1_reg.center.fixed_cell;
            s2_last_reg  <= s1_reg.last;
        end
        if (s3_load)
        begin
            sum_reg      <= sum_next;
            s3_q_reg     <= s2_q_reg;
            s3_fixed_reg <= s2_fixed_reg;
            s3_last_reg  <= s2_last_reg;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule
